// ===== rtl/core/histogram_localization_filter_macros.svh =====
// Assertion helpers used by the RTL sequencer
`ifndef HISTOGRAM_LOCALIZATION_FILTER_MACROS_SVH
`define HISTOGRAM_LOCALIZATION_FILTER_MACROS_SVH

// same-cycle implication
`define HLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlf assertion failed");

// next-cycle implication
`define HLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlf assertion failed");

`endif

// ===== rtl/core/hlf_pkg.sv =====
// ----------------------------------------------------------------------------
// hlf_pkg
// Shared constants, codes and types of the histogram localization filter.
// ----------------------------------------------------------------------------
package hlf_pkg;

  localparam int GRID_CELLS = 32;
  localparam int CELL_W     = 5;
  localparam int CNT_W      = 6;
  localparam int Q_W        = 16;
  localparam int SYM_W      = 8;
  localparam int DISP_W     = 6;
  localparam int SUM_W      = 22;
  localparam int ADDR_W     = 5;
  localparam int SUB_W      = 5;

  localparam logic [Q_W-1:0] UNIF_RST = 16'd2048;

  // item kinds
  localparam logic [1:0] KIND_MAP  = 2'd0;
  localparam logic [1:0] KIND_UNIF = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  // register indexes
  localparam logic [2:0] REG_CELLS = 3'd0;
  localparam logic [2:0] REG_HIT   = 3'd1;
  localparam logic [2:0] REG_MISS  = 3'd2;
  localparam logic [2:0] REG_UNDER = 3'd3;
  localparam logic [2:0] REG_EXACT = 3'd4;
  localparam logic [2:0] REG_OVER  = 3'd5;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_SENSE = 3'd1;
  localparam logic [2:0] OP_UNIF  = 3'd2;
  localparam logic [2:0] OP_NORM  = 3'd3;
  localparam logic [2:0] OP_MOD   = 3'd4;
  localparam logic [2:0] OP_MOVE  = 3'd5;
  localparam logic [2:0] OP_EMIT  = 3'd6;

  // normalize divider, move and sense substeps
  localparam logic [SUB_W-1:0] NORM_LOAD  = 5'd1;
  localparam logic [SUB_W-1:0] NORM_FIRST = 5'd2;
  localparam logic [SUB_W-1:0] NORM_WRITE = 5'd19;
  localparam logic [SUB_W-1:0] MOVE_WRITE = 5'd5;
  localparam logic [SUB_W-1:0] SENSE_WRITE = 5'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [SUB_W-1:0]  sub;
    logic [CELL_W-1:0] idx;
    logic              load;
    logic              map_we;
    logic              chk;
    logic              emit_ld;
    logic              last;
  } hlf_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic mod_done;
    logic out_free;
  } hlf_sts_t;

  // floor(65536/n), saturated
  function automatic logic [Q_W-1:0] unif_q(input logic [CNT_W-1:0] n);
    logic [Q_W-1:0] q;
    case (n)
      6'd1: q = 16'd65535;  6'd2: q = 16'd32768;  6'd3: q = 16'd21845;
      6'd4: q = 16'd16384;  6'd5: q = 16'd13107;  6'd6: q = 16'd10922;
      6'd7: q = 16'd9362;   6'd8: q = 16'd8192;   6'd9: q = 16'd7281;
      6'd10: q = 16'd6553;  6'd11: q = 16'd5957;  6'd12: q = 16'd5461;
      6'd13: q = 16'd5041;  6'd14: q = 16'd4681;  6'd15: q = 16'd4369;
      6'd16: q = 16'd4096;  6'd17: q = 16'd3855;  6'd18: q = 16'd3640;
      6'd19: q = 16'd3449;  6'd20: q = 16'd3276;  6'd21: q = 16'd3120;
      6'd22: q = 16'd2978;  6'd23: q = 16'd2849;  6'd24: q = 16'd2730;
      6'd25: q = 16'd2621;  6'd26: q = 16'd2520;  6'd27: q = 16'd2427;
      6'd28: q = 16'd2340;  6'd29: q = 16'd2259;  6'd30: q = 16'd2184;
      6'd31: q = 16'd2114;
      default: q = 16'd2048;
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/core/hlf_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlf_ctrl
// Sequencer: walks the cells through sense, normalize, move and report.
// ----------------------------------------------------------------------------
`include "histogram_localization_filter_macros.svh"

module hlf_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [1:0]                 in_kind,
  output logic                       in_stall,
  input  logic [hlf_pkg::CNT_W-1:0]  n,
  input  hlf_pkg::hlf_sts_t          sts,
  output hlf_pkg::hlf_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SENSE = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_UNIF  = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_MOVE  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [hlf_pkg::SUB_W-1:0]   sub_r, sub_nxt;
  logic [hlf_pkg::CELL_W-1:0]  idx_r, idx_nxt;
  logic                        zpath_r, zpath_nxt;
  logic [hlf_pkg::CELL_W-1:0]  nm1;
  logic                        at_end;
  logic                        acc;

  assign nm1      = hlf_pkg::CELL_W'(n - 6'd1);
  assign at_end   = (idx_r == nm1);
  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    sub_nxt     = sub_r;
    idx_nxt     = idx_r;
    zpath_nxt   = zpath_r;
    cmd         = '0;
    cmd.sub     = sub_r;
    cmd.idx     = idx_r;
    cmd.last    = at_end;
    case (state_r)
      S_IDLE: begin
        sub_nxt = '0;
        idx_nxt = '0;
        if (acc) begin
          cmd.load = 1'b1;
          case (in_kind)
            hlf_pkg::KIND_MAP:  cmd.map_we = 1'b1;
            hlf_pkg::KIND_UNIF: begin
              zpath_nxt = 1'b0;
              state_nxt = S_UNIF;
            end
            hlf_pkg::KIND_STEP: state_nxt = S_SENSE;
            default: ;
          endcase
        end
      end
      S_SENSE: begin
        cmd.op = hlf_pkg::OP_SENSE;
        if (sub_r == hlf_pkg::SENSE_WRITE) begin
          sub_nxt = '0;
          idx_nxt = idx_r + 5'd1;
          if (at_end) state_nxt = S_CHK;
        end else begin
          sub_nxt = sub_r + 5'd1;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        idx_nxt = '0;
        sub_nxt = '0;
        if (sts.sum_zero) begin
          zpath_nxt = 1'b1;
          state_nxt = S_UNIF;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_UNIF: begin
        cmd.op  = hlf_pkg::OP_UNIF;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == hlf_pkg::CELL_W'(hlf_pkg::GRID_CELLS - 1)) begin
          idx_nxt   = '0;
          state_nxt = zpath_r ? S_MOD : S_IDLE;
        end
      end
      S_NORM: begin
        cmd.op = hlf_pkg::OP_NORM;
        if (sub_r == hlf_pkg::NORM_WRITE) begin
          sub_nxt = '0;
          idx_nxt = idx_r + 5'd1;
          if (at_end) begin
            idx_nxt   = '0;
            state_nxt = S_MOD;
          end
        end else begin
          sub_nxt = sub_r + 5'd1;
        end
      end
      S_MOD: begin
        cmd.op = hlf_pkg::OP_MOD;
        if (sub_r == '0) begin
          sub_nxt = 5'd1;
        end else if (sts.mod_done) begin
          sub_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.op = hlf_pkg::OP_MOVE;
        if (sub_r == hlf_pkg::MOVE_WRITE) begin
          sub_nxt = '0;
          idx_nxt = idx_r + 5'd1;
          if (at_end) begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end
        end else begin
          sub_nxt = sub_r + 5'd1;
        end
      end
      S_EMIT: begin
        cmd.op = hlf_pkg::OP_EMIT;
        if (sub_r == '0) begin
          sub_nxt = 5'd1;
        end else if (sts.out_free) begin
          // hand this cell to the output register, advance
          cmd.emit_ld = 1'b1;
          sub_nxt     = '0;
          idx_nxt     = idx_r + 5'd1;
          if (at_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sub_r   <= '0;
      idx_r   <= '0;
      zpath_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      idx_r   <= idx_nxt;
      zpath_r <= zpath_nxt;
    end
  end

  `HLF_ASSERT_NEXT(a_step_starts, clk, rst_n, acc && in_kind == hlf_pkg::KIND_STEP, state_r == S_SENSE)
  `HLF_ASSERT_NEXT(a_last_ends, clk, rst_n, cmd.emit_ld && cmd.last, state_r == S_IDLE)
  `HLF_ASSERT_IMP(a_move_sub, clk, rst_n, state_r == S_MOVE, sub_r <= hlf_pkg::MOVE_WRITE)

endmodule

// ===== rtl/core/hlf_dp.sv =====
// ----------------------------------------------------------------------------
// hlf_dp
// Datapath: belief, map and work stores, shared multiplier, serial divider,
// cyclic index reducer and the result register.
// ----------------------------------------------------------------------------
module hlf_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hlf_pkg::hlf_cmd_t          cmd,
  output hlf_pkg::hlf_sts_t          sts,
  input  logic [hlf_pkg::CNT_W-1:0]  n,
  input  logic [15:0]                hit_w,
  input  logic [15:0]                miss_w,
  input  logic [15:0]                under_w,
  input  logic [15:0]                exact_w,
  input  logic [15:0]                over_w,
  input  logic [4:0]                 in_cell_index,
  input  logic [7:0]                 in_symbol,
  input  logic signed [5:0]          in_displacement,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [4:0]                 out_out_cell,
  output logic [15:0]                out_probability,
  output logic                       out_last,
  output logic                       out_zero_sum
);

  logic [7:0]  map_mem [hlf_pkg::GRID_CELLS];
  logic [15:0] bel_mem [hlf_pkg::GRID_CELLS];
  logic [15:0] nrm_mem [hlf_pkg::GRID_CELLS];
  logic [hlf_pkg::GRID_CELLS-1:0] bel_vld_r;

  logic [7:0]  sym_r, map_rd_r;
  logic [5:0]  disp_r;
  logic [15:0] bel_rd_r, nrm_rd_r;
  logic [31:0] prod_r;
  logic [17:0] acc_r;
  logic [21:0] sum_r;
  logic [22:0] rem_r;
  logic [16:0] quo_r;
  logic [6:0]  ptr_r;
  logic        zero_r;
  logic        out_valid_r;
  logic [4:0]  out_cell_r;
  logic [15:0] out_prob_r;
  logic        out_last_r, out_zero_r;

  logic [4:0]  nm1, e_idx, u_idx, o_idx, nrm_ra;
  logic [15:0] wt, mul_a, mul_b, uq, acc_sat;
  logic [22:0] div_t;
  logic        div_ge;
  logic        ptr_neg, ptr_hi;

  assign nm1   = 5'(n - 6'd1);
  assign e_idx = ptr_r[4:0];
  assign u_idx = (e_idx == nm1) ? 5'd0 : e_idx + 5'd1;
  assign o_idx = (e_idx == 5'd0) ? nm1 : e_idx - 5'd1;

  always_comb begin
    case (cmd.op)
      hlf_pkg::OP_MOVE: begin
        if (cmd.sub == 5'd0)      nrm_ra = e_idx;
        else if (cmd.sub == 5'd1) nrm_ra = u_idx;
        else                      nrm_ra = o_idx;
      end
      default: nrm_ra = cmd.idx;
    endcase
  end

  assign wt    = (map_rd_r == sym_r) ? hit_w : miss_w;
  assign mul_a = (cmd.op == hlf_pkg::OP_SENSE) ? bel_rd_r : nrm_rd_r;
  always_comb begin
    if (cmd.op == hlf_pkg::OP_SENSE) mul_b = wt;
    else if (cmd.sub == 5'd1)        mul_b = exact_w;
    else if (cmd.sub == 5'd2)        mul_b = under_w;
    else                             mul_b = over_w;
  end

  // restoring divide, quotient bit 16 first without a shift
  assign div_t  = (cmd.sub == hlf_pkg::NORM_FIRST) ? rem_r : {rem_r[21:0], 1'b0};
  assign div_ge = (div_t >= {1'b0, sum_r});

  assign uq      = ({1'b0, cmd.idx} < n) ? hlf_pkg::unif_q(n) : 16'd0;
  assign acc_sat = (acc_r > 18'd65535) ? 16'hFFFF : acc_r[15:0];

  assign ptr_neg = ptr_r[6];
  assign ptr_hi  = !ptr_neg && (ptr_r >= {1'b0, n});

  assign sts.sum_zero = (sum_r == '0);
  assign sts.mod_done = !ptr_neg && !ptr_hi;
  assign sts.out_free = !out_valid_r || !out_stall;

  // stores
  always_ff @(posedge clk) begin
    if (cmd.map_we) map_mem[in_cell_index] <= in_symbol;
    map_rd_r <= map_mem[cmd.idx];
    bel_rd_r <= bel_vld_r[cmd.idx] ? bel_mem[cmd.idx] : hlf_pkg::UNIF_RST;
    nrm_rd_r <= nrm_mem[nrm_ra];
    if (cmd.op == hlf_pkg::OP_UNIF) begin
      bel_mem[cmd.idx] <= uq;
      nrm_mem[cmd.idx] <= uq;
    end else if (cmd.op == hlf_pkg::OP_MOVE && cmd.sub == hlf_pkg::MOVE_WRITE) begin
      bel_mem[cmd.idx] <= acc_sat;
    end else if (cmd.op == hlf_pkg::OP_SENSE && cmd.sub == hlf_pkg::SENSE_WRITE) begin
      nrm_mem[cmd.idx] <= prod_r[31:16];
    end else if (cmd.op == hlf_pkg::OP_NORM && cmd.sub == hlf_pkg::NORM_WRITE) begin
      nrm_mem[cmd.idx] <= quo_r[16] ? 16'hFFFF : quo_r[15:0];
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      sym_r  <= in_symbol;
      disp_r <= in_displacement;
      sum_r  <= '0;
    end
    if (cmd.op == hlf_pkg::OP_SENSE && cmd.sub == hlf_pkg::SENSE_WRITE)
      sum_r <= sum_r + 22'(prod_r[31:16]);
    if (cmd.chk) zero_r <= (sum_r == '0);
    if (cmd.op == hlf_pkg::OP_NORM) begin
      if (cmd.sub == hlf_pkg::NORM_LOAD) begin
        rem_r <= {7'd0, nrm_rd_r};
        quo_r <= '0;
      end else if (cmd.sub != hlf_pkg::NORM_WRITE && cmd.sub != 5'd0) begin
        rem_r <= div_ge ? (div_t - {1'b0, sum_r}) : div_t;
        quo_r <= {quo_r[15:0], div_ge};
      end
    end
    if (cmd.op == hlf_pkg::OP_MOD) begin
      if (cmd.sub == 5'd0)   ptr_r <= 7'd0 - {disp_r[5], disp_r};
      else if (ptr_neg)      ptr_r <= ptr_r + {1'b0, n};
      else if (ptr_hi)       ptr_r <= ptr_r - {1'b0, n};
    end
    if (cmd.op == hlf_pkg::OP_MOVE) begin
      case (cmd.sub)
        5'd2: acc_r <= 18'(prod_r[31:16]);
        5'd3, 5'd4: acc_r <= acc_r + 18'(prod_r[31:16]);
        hlf_pkg::MOVE_WRITE: ptr_r <= {2'b00, u_idx};
        default: ;
      endcase
    end
    if (cmd.emit_ld) begin
      out_cell_r <= cmd.idx;
      out_prob_r <= bel_rd_r;
      out_last_r <= cmd.last;
      out_zero_r <= zero_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bel_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == hlf_pkg::OP_UNIF ||
          (cmd.op == hlf_pkg::OP_MOVE && cmd.sub == hlf_pkg::MOVE_WRITE))
        bel_vld_r[cmd.idx] <= 1'b1;
      if (cmd.emit_ld)       out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_cell    = out_cell_r;
  assign out_probability = out_prob_r;
  assign out_last        = out_last_r;
  assign out_zero_sum    = out_zero_r;

endmodule

// ===== rtl/core/histogram_localization_filter.sv =====
// ----------------------------------------------------------------------------
// histogram_localization_filter
// Cyclic 1-D histogram localization filter with APB register port.
// ----------------------------------------------------------------------------
// Map writes (kind 0) store the symbol without leaving idle. A uniform reset
// (kind 1) sweeps all 32 cells, one a cycle. A step (kind 2) runs sense over
// each active cell, then normalize per cell (one quotient bit a cycle in a
// shared restoring divider), a cyclic index reduction of the displacement,
// the three-way move per cell through one 16x16 multiplier, and a report per
// cell that waits while the output register is stalled. When the weighted
// sum is zero, normalize is skipped and a uniform sweep of all 32 cells
// takes its place.
// One item is in work at a time; the last result may still wait in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module histogram_localization_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [4:0]                  in_cell_index,
  input  logic [7:0]                  in_symbol,
  input  logic signed [5:0]           in_displacement,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  out_out_cell,
  output logic [15:0]                 out_probability,
  output logic                        out_last,
  output logic                        out_zero_sum,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [5:0]  cells_r;
  logic [15:0] hit_r, miss_r, under_r, exact_r, over_r;
  logic [2:0]  reg_idx;
  logic        wr;
  logic [hlf_pkg::CNT_W-1:0] n;

  hlf_pkg::hlf_cmd_t cmd;
  hlf_pkg::hlf_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= 6'd32;
      hit_r   <= 16'd39322;
      miss_r  <= 16'd13107;
      under_r <= 16'd6554;
      exact_r <= 16'd52429;
      over_r  <= 16'd6554;
    end else if (wr) begin
      case (reg_idx)
        hlf_pkg::REG_CELLS: cells_r <= pwdata[5:0];
        hlf_pkg::REG_HIT:   hit_r   <= pwdata[15:0];
        hlf_pkg::REG_MISS:  miss_r  <= pwdata[15:0];
        hlf_pkg::REG_UNDER: under_r <= pwdata[15:0];
        hlf_pkg::REG_EXACT: exact_r <= pwdata[15:0];
        hlf_pkg::REG_OVER:  over_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hlf_pkg::REG_CELLS: prdata = {26'd0, cells_r};
      hlf_pkg::REG_HIT:   prdata = {16'd0, hit_r};
      hlf_pkg::REG_MISS:  prdata = {16'd0, miss_r};
      hlf_pkg::REG_UNDER: prdata = {16'd0, under_r};
      hlf_pkg::REG_EXACT: prdata = {16'd0, exact_r};
      hlf_pkg::REG_OVER:  prdata = {16'd0, over_r};
      default:            prdata = 32'd0;
    endcase
  end

  // clamp active cell count to 1..GRID_CELLS
  always_comb begin
    if (cells_r == '0)
      n = 6'd1;
    else if (cells_r > hlf_pkg::CNT_W'(hlf_pkg::GRID_CELLS))
      n = hlf_pkg::CNT_W'(hlf_pkg::GRID_CELLS);
    else
      n = cells_r;
  end

  hlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .n        (n),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .n               (n),
    .hit_w           (hit_r),
    .miss_w          (miss_r),
    .under_w         (under_r),
    .exact_w         (exact_r),
    .over_w          (over_r),
    .in_cell_index   (in_cell_index),
    .in_symbol       (in_symbol),
    .in_displacement (in_displacement),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_cell    (out_out_cell),
    .out_probability (out_probability),
    .out_last        (out_last),
    .out_zero_sum    (out_zero_sum)
  );

endmodule

// ===== bench/histogram_localization_filter_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// histogram_localization_filter_tb
// Drives map loads, uniform resets and sense/move steps into the filter with
// random idling on both channels, predicts every reported cell belief, and
// compares each result beat with the prediction in order.
// ============================================================================

typedef struct {
  logic [4:0]  cell_idx;
  logic [15:0] prob;
  logic        last;
  logic        zsum;
} cell_report_t;

class belief_scoreboard;
  int unsigned n_cfg;
  int unsigned w_hit, w_miss, w_under, w_exact, w_over;
  logic [15:0] belief[hlf_pkg::GRID_CELLS];
  logic [7:0]  map_sym[hlf_pkg::GRID_CELLS];
  cell_report_t pending[$];
  int errors;
  int steps;
  int zero_steps;

  function new();
    n_cfg = 32; w_hit = 39322; w_miss = 13107;
    w_under = 6554; w_exact = 52429; w_over = 6554;
    foreach (map_sym[i]) map_sym[i] = 8'd0;
    errors = 0; steps = 0; zero_steps = 0;
    make_uniform(active_n());
  endfunction

  function int unsigned active_n();
    if (n_cfg < 1) return 1;
    if (n_cfg > hlf_pkg::GRID_CELLS) return hlf_pkg::GRID_CELLS;
    return n_cfg;
  endfunction

  function void make_uniform(int unsigned n);
    longint unsigned q;
    q = 65536 / n;
    if (q > 65535) q = 65535;
    foreach (belief[i]) belief[i] = (i < n) ? q[15:0] : 16'd0;
  endfunction

  function void set_reg(int idx, int unsigned v);
    case (idx)
      hlf_pkg::REG_CELLS: n_cfg = v & 32'h3f;
      hlf_pkg::REG_HIT:   w_hit = v & 32'hffff;
      hlf_pkg::REG_MISS:  w_miss = v & 32'hffff;
      hlf_pkg::REG_UNDER: w_under = v & 32'hffff;
      hlf_pkg::REG_EXACT: w_exact = v & 32'hffff;
      hlf_pkg::REG_OVER:  w_over = v & 32'hffff;
      default: ;
    endcase
  endfunction

  function void note_item(logic [1:0] kind, logic [4:0] idx, logic [7:0] sym,
                          logic signed [5:0] disp);
    int unsigned n, sum, pe, pu, po;
    longint unsigned v, acc[hlf_pkg::GRID_CELLS];
    int dm, base;
    bit zero;
    cell_report_t r;
    n = active_n();
    if (kind == hlf_pkg::KIND_MAP) begin
      map_sym[idx] = sym;
      return;
    end
    if (kind == hlf_pkg::KIND_UNIF) begin
      make_uniform(n);
      return;
    end
    if (kind != hlf_pkg::KIND_STEP) return;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      v = (longint'(belief[i]) * ((map_sym[i] == sym) ? w_hit : w_miss)) >> 16;
      belief[i] = v[15:0];
      sum = sum + 32'(v);
    end
    zero = (sum == 0);
    if (zero) make_uniform(n);
    else
      for (int i = 0; i < n; i++) begin
        v = (longint'(belief[i]) << 16) / sum;
        belief[i] = (v > 65535) ? 16'hffff : v[15:0];
      end
    dm = int'(disp) % int'(n);
    if (dm < 0) dm += n;
    foreach (acc[i]) acc[i] = 0;
    for (int i = 0; i < n; i++) begin
      base = i + dm + n;
      pe = base % n; pu = (base - 1) % n; po = (base + 1) % n;
      acc[pe] += (longint'(belief[i]) * w_exact) >> 16;
      acc[pu] += (longint'(belief[i]) * w_under) >> 16;
      acc[po] += (longint'(belief[i]) * w_over) >> 16;
    end
    for (int i = 0; i < n; i++) begin
      belief[i] = (acc[i] > 65535) ? 16'hffff : acc[i][15:0];
      r.cell_idx = 5'(i); r.prob = belief[i]; r.last = (i + 1 == n); r.zsum = zero;
      pending.push_back(r);
    end
    steps++;
    if (zero) zero_steps++;
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task check_beat(cell_report_t got);
    cell_report_t w;
    if (pending.size() == 0) begin
      report("unexpected result beat, cell", got.cell_idx, -1);
      return;
    end
    w = pending.pop_front();
    if (got.cell_idx !== w.cell_idx) report("cell", got.cell_idx, w.cell_idx);
    if (got.prob !== w.prob) report("probability", got.prob, w.prob);
    if (got.last !== w.last) report("last", got.last, w.last);
    if (got.zsum !== w.zsum) report("zero_sum", got.zsum, w.zsum);
  endtask
endclass

module histogram_localization_filter_tb;
  localparam int IDLE_PCT = 27;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [4:0] in_cell_index;
  logic [7:0] in_symbol;
  logic signed [5:0] in_displacement;
  logic out_valid, out_stall;
  logic [4:0] out_out_cell;
  logic [15:0] out_probability;
  logic out_last, out_zero_sum;
  logic psel, penable, pwrite;
  logic [hlf_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  belief_scoreboard sb;
  bit calm;          // no idling on either side
  bit hold_off;      // receiver holds off for a long stretch
  int idle_cycles;

  histogram_localization_filter uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cell_report_t b;
    if (rst_n && out_valid && !out_stall) begin
      b.cell_idx = out_out_cell; b.prob = out_probability;
      b.last = out_last; b.zsum = out_zero_sum;
      sb.check_beat(b);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high into the next beat unless the sender idles
  task automatic send(logic [1:0] kind, logic [4:0] idx, logic [7:0] sym,
                      logic signed [5:0] disp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind; in_cell_index <= idx;
    in_symbol <= sym; in_displacement <= disp;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, idx, sym, disp);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= hlf_pkg::ADDR_W'(4 * idx); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // fill every map cell so no unwritten cell is ever sensed
  task automatic load_map(bit narrow);
    for (int i = 0; i < hlf_pkg::GRID_CELLS; i++)
      send(hlf_pkg::KIND_MAP, 5'(i), narrow ? 8'($urandom_range(3)) : 8'($urandom),
           6'sd0);
  endtask

  task automatic random_steps(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 12)
        send(hlf_pkg::KIND_MAP, 5'($urandom), 8'($urandom_range(3)), 6'($urandom));
      else if (k < 18)
        send(hlf_pkg::KIND_UNIF, 5'($urandom), 8'($urandom), 6'($urandom));
      else if (k < 21)
        send(KIND_NONE, 5'($urandom), 8'($urandom), 6'($urandom));
      else
        send(hlf_pkg::KIND_STEP, 5'($urandom),
             (k < 30) ? 8'($urandom) : 8'($urandom_range(3)), 6'($urandom));
    end
  endtask

  initial begin
    sb = new();
    calm = 0; hold_off = 0; idle_cycles = 0;
    in_valid = 0; in_kind = hlf_pkg::KIND_MAP; in_cell_index = 0; in_symbol = 0;
    in_displacement = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme symbols and displacements at reset settings
    load_map(1'b0);
    send(hlf_pkg::KIND_MAP, 5'd0, 8'hff, 6'sd0);
    send(hlf_pkg::KIND_MAP, 5'd31, 8'h00, 6'sd0);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'hff, 6'sd31);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h00, -6'sd32);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h5a, 6'sd0);
    send(KIND_NONE, 5'd31, 8'hff, -6'sd1);
    send(hlf_pkg::KIND_UNIF, 5'd0, 8'd0, 6'sd0);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'haa, -6'sd31);
    drain();

    // zero weights force the zero-sum path; single active cell
    write_reg(hlf_pkg::REG_HIT, 0); write_reg(hlf_pkg::REG_MISS, 0);
    write_reg(hlf_pkg::REG_CELLS, 1);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h01, 6'sd5);
    drain();
    write_reg(hlf_pkg::REG_CELLS, 0);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h02, -6'sd7);
    drain();
    write_reg(hlf_pkg::REG_CELLS, 63);
    write_reg(hlf_pkg::REG_HIT, 32'hffff); write_reg(hlf_pkg::REG_MISS, 32'hffff);
    write_reg(hlf_pkg::REG_UNDER, 32'hffff); write_reg(hlf_pkg::REG_EXACT, 32'hffff);
    write_reg(hlf_pkg::REG_OVER, 32'hffff);
    write_reg(REG_UNUSED, 32'h1234);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h03, 6'sd1);
    send(hlf_pkg::KIND_STEP, 5'd0, 8'h03, -6'sd2);
    drain();

    // random phases over several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(hlf_pkg::REG_CELLS, (ph == 0) ? 2 : (ph == 1) ? 32 : $urandom_range(1, 32));
      write_reg(hlf_pkg::REG_HIT, (ph == 2) ? 0 : $urandom);
      write_reg(hlf_pkg::REG_MISS, (ph == 2) ? 0 : $urandom);
      write_reg(hlf_pkg::REG_UNDER, $urandom);
      write_reg(hlf_pkg::REG_EXACT, (ph == 3) ? 32'hffff : $urandom);
      write_reg(hlf_pkg::REG_OVER, $urandom);
      calm = (ph == 4);
      load_map(1'b1);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering items
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
          random_steps(12);
        join
      end
      else random_steps(14);
      drain();
    end
    calm = 0;

    $display("covered %0d steps (%0d with zero weighted sum) across directed and six random settings",
             sb.steps, sb.zero_steps);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== histogram_localization_filter.f =====
+incdir+rtl/core
rtl/core/hlf_pkg.sv
rtl/core/hlf_ctrl.sv
rtl/core/hlf_dp.sv
rtl/core/histogram_localization_filter.sv
bench/histogram_localization_filter_tb.sv
